// ----- rtl/luhn_pkg.sv -----
package luhn_pkg;

    // field widths
    localparam int CARD_W       = 63;
    localparam int CLASS_W      = 2;
    localparam int COUNT_W      = 5;
    localparam int SUM_W        = 8;

    // a 63-bit value has at most 19 decimal digits
    localparam int BCD_DIGITS   = 19;
    localparam int BCD_W        = 4 * BCD_DIGITS;

    // defaults and limits
    localparam int MAX_DIGITS_DEF = 19;
    localparam int MIN_LENGTH     = 13;

    typedef logic [CARD_W-1:0]  card_number_t;
    typedef logic [CLASS_W-1:0] card_class_t;
    typedef logic [COUNT_W-1:0] digit_total_t;
    typedef logic [SUM_W-1:0]   luhn_total_t;
    typedef logic [3:0]         digit_t;

    // brand codes on card_class
    typedef enum logic [CLASS_W-1:0] {
        CLASS_INVALID = 2'd0,
        CLASS_BRAND1  = 2'd1,
        CLASS_BRAND2  = 2'd2,
        CLASS_BRAND3  = 2'd3
    } class_code_t;

endpackage

// ----- rtl/luhn_card_number_check.sv -----
// Luhn mod-10 card number check with brand classification.
//
// Channels: a request is taken on the rising edge where start is high and
// busy is low; card_number is sampled at that edge. The result (card_class,
// checksum_ok, digit_total, luhn_total) is shown for exactly one cycle with
// done high and is not held off by the receiver, which cannot stall.
//
// Operation: the binary number is turned into 19 BCD digits by a shift-and-add-3
// converter, one input bit per cycle. The BCD register is then scanned one digit
// per cycle from the least significant end, while digits remain, up to MAX_DIGITS
// digits (so 0 to MAX_DIGITS digits are examined), and a final step classifies
// the number. busy stays high from the accepting edge until done, and a new
// request may be taken in the cycle where done is high.
//
// Reset: rst_n clears the controller to idle with busy and done low; results
// read as zero until the first request completes.
module luhn_card_number_check #(
    parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  luhn_pkg::card_number_t  card_number,
    output logic                    done,
    output luhn_pkg::card_class_t   card_class,
    output logic                    checksum_ok,
    output luhn_pkg::digit_total_t  digit_total,
    output luhn_pkg::luhn_total_t   luhn_total
);

    import luhn_pkg::*;

    localparam int BIT_CNT_W = $clog2(CARD_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN
    } state_t;

    state_t                 state_reg, state_next;
    card_number_t           bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    digit_total_t           count_reg, count_next;
    luhn_total_t            sum_reg, sum_next;
    digit_t                 mod_reg, mod_next;
    digit_t                 lead_reg, lead_next;
    digit_t                 second_reg, second_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    card_class_t            class_reg, class_next;
    logic                   ok_reg, ok_next;
    digit_total_t           total_reg, total_next;
    luhn_total_t            luhn_reg, luhn_next;

    // add 3 to every BCD digit of 5 or more before the shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v;
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (v[4*k +: 4] >= 4'd5)
            begin
                r[4*k +: 4] = v[4*k +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // digit contribution for the current scan position
    logic [BCD_W-1:0] bcd_adj;
    digit_t       digit;
    logic [4:0]   doubled;
    digit_t       contrib;
    logic [4:0]   mod_sum;
    logic         more_digits;
    logic         sum_ok;
    class_code_t  class_code;

    always_comb
    begin
        bcd_adj = bcd_adjust(bcd_reg);
        digit   = bcd_reg[3:0];
        doubled = {digit, 1'b0};
        if (count_reg[0])
        begin
            contrib = (doubled >= 5'd10) ? 4'(doubled - 5'd9) : doubled[3:0];
        end
        else
        begin
            contrib = digit;
        end
        mod_sum     = {1'b0, mod_reg} + {1'b0, contrib};
        more_digits = (bcd_reg != '0) && (count_reg < COUNT_W'(MAX_DIGITS));
        sum_ok      = (mod_reg == 4'd0);
    end

    // brand from the two leading digits of a passing number
    always_comb
    begin
        class_code = CLASS_INVALID;
        if (sum_ok && (bcd_reg == '0) && (count_reg >= COUNT_W'(MIN_LENGTH)))
        begin
            if (lead_reg == 4'd4)
            begin
                class_code = CLASS_BRAND1;
            end
            else if ((lead_reg == 4'd3) && (second_reg inside {4'd4, 4'd7}))
            begin
                class_code = CLASS_BRAND2;
            end
            else if ((lead_reg == 4'd5) && (second_reg inside {[4'd1:4'd5]}))
            begin
                class_code = CLASS_BRAND3;
            end
        end
    end

    // next-state logic
    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        mod_next     = mod_reg;
        lead_next    = lead_reg;
        second_next  = second_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        class_next   = class_reg;
        ok_next      = ok_reg;
        total_next   = total_reg;
        luhn_next    = luhn_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    bin_next     = card_number;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    count_next   = '0;
                    sum_next     = '0;
                    mod_next     = '0;
                    lead_next    = '0;
                    second_next  = '0;
                    busy_next    = 1'b1;
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                // shift one binary bit into the BCD register
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[CARD_W-1]};
                bin_next     = {bin_reg[CARD_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(CARD_W - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (more_digits)
                begin
                    // accumulate one digit, least significant first
                    sum_next    = sum_reg + {4'b0, contrib};
                    mod_next    = (mod_sum >= 5'd10) ? 4'(mod_sum - 5'd10) : mod_sum[3:0];
                    second_next = lead_reg;
                    lead_next   = digit;
                    count_next  = count_reg + 1'b1;
                    bcd_next    = {4'b0, bcd_reg[BCD_W-1:4]};
                end
                else
                begin
                    // classify and present the result
                    class_next = card_class_t'(class_code);
                    ok_next    = sum_ok;
                    total_next = count_reg;
                    luhn_next  = sum_reg;
                    done_next  = 1'b1;
                    busy_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bin_reg     <= '0;
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            mod_reg     <= '0;
            lead_reg    <= '0;
            second_reg  <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            class_reg   <= '0;
            ok_reg      <= 1'b0;
            total_reg   <= '0;
            luhn_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bin_reg     <= bin_next;
            bcd_reg     <= bcd_next;
            bit_cnt_reg <= bit_cnt_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            mod_reg     <= mod_next;
            lead_reg    <= lead_next;
            second_reg  <= second_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            class_reg   <= class_next;
            ok_reg      <= ok_next;
            total_reg   <= total_next;
            luhn_reg    <= luhn_next;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign card_class  = class_reg;
    assign checksum_ok = ok_reg;
    assign digit_total = total_reg;
    assign luhn_total  = luhn_reg;

endmodule
